@@ src/evs_mime_frame_deframer_assert.svh @@
// Assertion macros for the EVS MIME storage-format deframer.
// Included by the checker; needs no other file.
`ifndef EVS_MIME_FRAME_DEFRAMER_ASSERT_SVH
`define EVS_MIME_FRAME_DEFRAMER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define EMFD_CHECK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define EMFD_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/emfd_pkg.sv @@
// Shared types, constants and lookup tables for the EVS MIME deframer.
// No dependencies; used by the top level and the checker.
`timescale 1ns / 1ps

package emfd_pkg;

  localparam int HEADER_BYTES = 16;
  localparam int MAGIC_BYTES = 12;
  localparam logic [8:0] MAX_FRAME_BYTES = 9'd320;

  localparam logic [3:0] RATE_MASK = 4'hF;
  localparam logic [3:0] RATE_BAD_FIRST = 4'd13;

  typedef enum logic [1:0] {
    KIND_DESC    = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  localparam logic FAULT_MAGIC = 1'b0;
  localparam logic FAULT_CHANNELS = 1'b1;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_TOC     = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_HALTED  = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] payload_byte;
    logic       amrwb_io_mode;
    logic [3:0] rate_index;
    logic [8:0] frame_bytes;
    logic       bad_frame;
    logic       last_of_frame;
    logic       header_fault;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] pos);
    logic [7:0] b;
    unique case (pos)
      4'd0:    b = 8'h23;
      4'd1:    b = 8'h21;
      4'd2:    b = 8'h45;
      4'd3:    b = 8'h56;
      4'd4:    b = 8'h53;
      4'd5:    b = 8'h5F;
      4'd6:    b = 8'h4D;
      4'd7:    b = 8'h43;
      4'd8:    b = 8'h31;
      4'd9:    b = 8'h2E;
      4'd10:   b = 8'h30;
      4'd11:   b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [8:0] primary_len(input logic [3:0] idx);
    logic [8:0] n;
    unique case (idx)
      4'd0:    n = 9'd7;
      4'd1:    n = 9'd18;
      4'd2:    n = 9'd20;
      4'd3:    n = 9'd24;
      4'd4:    n = 9'd33;
      4'd5:    n = 9'd41;
      4'd6:    n = 9'd61;
      4'd7:    n = 9'd80;
      4'd8:    n = 9'd120;
      4'd9:    n = 9'd160;
      4'd10:   n = 9'd240;
      4'd11:   n = 9'd320;
      4'd12:   n = 9'd6;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] amrwb_len(input logic [3:0] idx);
    logic [8:0] n;
    unique case (idx)
      4'd0:    n = 9'd17;
      4'd1:    n = 9'd23;
      4'd2:    n = 9'd32;
      4'd3:    n = 9'd36;
      4'd4:    n = 9'd40;
      4'd5:    n = 9'd46;
      4'd6:    n = 9'd50;
      4'd7:    n = 9'd58;
      4'd8:    n = 9'd60;
      4'd9:    n = 9'd5;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] frame_len(input logic mode, input logic [3:0] idx);
    logic [8:0] n;
    n = mode ? amrwb_len(idx) : primary_len(idx);
    return (n > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : n;
  endfunction

endpackage

@@ src/evs_mime_frame_deframer.sv @@
// Top level of the EVS MIME storage-format deframer: header check, ToC decode
// and payload pass-through, with a result register and a skid stage.
// Depends on emfd_pkg.
//
//   channel   direction  handshake                   payload
//   stream    in         stream_valid/stream_stall   stream_byte
//   result    out        result_valid/result_stall   result_kind .. header_fault
//
// One byte per cycle while stream_stall is low; every beat is decoded in the
// cycle it is accepted and any result it gives is registered.
// The first 16 beats are header; a bad header gives one error result and
// then every beat is dropped until rst. stream_stall rises only while the
// skid stage holds a result behind a stalled output register.
`timescale 1ns / 1ps

module evs_mime_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       stream_valid,
  output logic       stream_stall,
  input  logic [7:0] stream_byte,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] result_kind,
  output logic [7:0] payload_byte,
  output logic       amrwb_io_mode,
  output logic [3:0] rate_index,
  output logic [8:0] frame_bytes,
  output logic       bad_frame,
  output logic       last_of_frame,
  output logic       header_fault
);

  localparam logic [4:0] HEADER_LAST = 5'(emfd_pkg::HEADER_BYTES - 1);
  localparam logic [4:0] MAGIC_END = 5'(emfd_pkg::MAGIC_BYTES);

  emfd_pkg::phase_t  phase, phase_next;
  logic [4:0]        header_position, header_position_next;
  logic              magic_matched, magic_matched_next;
  logic [31:0]       channel_accumulator, channel_accumulator_next;
  logic [8:0]        payload_remaining, payload_remaining_next;

  emfd_pkg::result_t res_next, out_reg, skid_reg;
  logic              res_hit;
  logic              out_valid, skid_full;
  logic              accept, out_fire;

  logic              toc_mode;
  logic [3:0]        toc_idx;
  logic [8:0]        toc_len;

  assign accept = stream_valid && !stream_stall;
  assign out_fire = out_valid && !result_stall;
  assign stream_stall = skid_full;

  assign toc_mode = stream_byte[5];
  assign toc_idx = stream_byte[3:0] & emfd_pkg::RATE_MASK;
  assign toc_len = emfd_pkg::frame_len(toc_mode, toc_idx);

  always_comb begin
    phase_next = phase;
    header_position_next = header_position;
    magic_matched_next = magic_matched;
    channel_accumulator_next = channel_accumulator;
    payload_remaining_next = payload_remaining;
    res_next = '0;
    res_hit = 1'b0;
    unique case (phase)
      emfd_pkg::PH_HEADER: begin
        if (header_position < MAGIC_END) begin
          if (stream_byte != emfd_pkg::magic_byte(header_position[3:0])) begin
            magic_matched_next = 1'b0;
          end
        end else begin
          channel_accumulator_next = {channel_accumulator[23:0], stream_byte};
        end
        header_position_next = header_position + 5'd1;
        if (header_position == HEADER_LAST) begin
          if (!magic_matched || channel_accumulator_next != 32'd1) begin
            res_hit = 1'b1;
            res_next.kind = emfd_pkg::KIND_ERROR;
            res_next.header_fault = magic_matched ? emfd_pkg::FAULT_CHANNELS
                                                  : emfd_pkg::FAULT_MAGIC;
            phase_next = emfd_pkg::PH_HALTED;
          end else begin
            phase_next = emfd_pkg::PH_TOC;
          end
        end
      end
      emfd_pkg::PH_TOC: begin
        res_hit = 1'b1;
        res_next.kind = emfd_pkg::KIND_DESC;
        res_next.amrwb_io_mode = toc_mode;
        res_next.rate_index = toc_idx;
        res_next.frame_bytes = toc_len;
        res_next.bad_frame = (toc_idx >= emfd_pkg::RATE_BAD_FIRST);
        res_next.last_of_frame = (toc_len == 9'd0);
        if (toc_len != 9'd0) begin
          payload_remaining_next = toc_len;
          phase_next = emfd_pkg::PH_PAYLOAD;
        end
      end
      emfd_pkg::PH_PAYLOAD: begin
        res_hit = 1'b1;
        res_next.kind = emfd_pkg::KIND_PAYLOAD;
        res_next.payload_byte = stream_byte;
        if (payload_remaining != 9'd0) begin
          payload_remaining_next = payload_remaining - 9'd1;
        end
        if (payload_remaining_next == 9'd0) begin
          res_next.last_of_frame = 1'b1;
          phase_next = emfd_pkg::PH_TOC;
        end
      end
      emfd_pkg::PH_HALTED: begin
      end
      default: begin
        phase_next = emfd_pkg::PH_HALTED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= emfd_pkg::PH_HEADER;
      header_position <= '0;
      magic_matched <= 1'b1;
      channel_accumulator <= '0;
      payload_remaining <= '0;
    end else if (accept) begin
      phase <= phase_next;
      header_position <= header_position_next;
      magic_matched <= magic_matched_next;
      channel_accumulator <= channel_accumulator_next;
      payload_remaining <= payload_remaining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_fire) begin
        skid_full <= 1'b0;
      end
    end else if (accept && res_hit) begin
      if (!out_valid || out_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_fire) begin
        out_reg <= skid_reg;
      end
    end else if (accept && res_hit) begin
      if (!out_valid || out_fire) begin
        out_reg <= res_next;
      end else begin
        skid_reg <= res_next;
      end
    end
  end

  assign result_valid = out_valid;
  assign result_kind = out_reg.kind;
  assign payload_byte = out_reg.payload_byte;
  assign amrwb_io_mode = out_reg.amrwb_io_mode;
  assign rate_index = out_reg.rate_index;
  assign frame_bytes = out_reg.frame_bytes;
  assign bad_frame = out_reg.bad_frame;
  assign last_of_frame = out_reg.last_of_frame;
  assign header_fault = out_reg.header_fault;

endmodule

@@ src/emfd_checker.sv @@
// Port-level checker for the EVS MIME deframer, bound to the top level.
// Depends on emfd_pkg and evs_mime_frame_deframer_assert.svh.
`timescale 1ns / 1ps
`include "evs_mime_frame_deframer_assert.svh"

module emfd_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_stall,
  input logic [1:0] result_kind,
  input logic [7:0] payload_byte,
  input logic       amrwb_io_mode,
  input logic [3:0] rate_index,
  input logic [8:0] frame_bytes,
  input logic       bad_frame,
  input logic       last_of_frame,
  input logic       header_fault
);

  `EMFD_CHECK_ALWAYS(a_reset_empty, clk, rst |=> !result_valid, "result beat right after reset")

  `EMFD_CHECK(a_hold_stalled, clk, rst, result_valid && result_stall |=> result_valid && $stable(result_kind) && $stable(payload_byte) && $stable(frame_bytes) && $stable(amrwb_io_mode) && $stable(header_fault), "stalled result beat changed")

  `EMFD_CHECK(a_kind_legal, clk, rst, result_valid |-> (result_kind == emfd_pkg::KIND_DESC || result_kind == emfd_pkg::KIND_PAYLOAD || result_kind == emfd_pkg::KIND_ERROR), "unknown result kind")

  `EMFD_CHECK(a_payload_clean, clk, rst, result_valid && result_kind != emfd_pkg::KIND_PAYLOAD |-> payload_byte == 8'd0, "payload byte set on non-payload beat")

  `EMFD_CHECK(a_desc_bad, clk, rst, result_valid && result_kind == emfd_pkg::KIND_DESC |-> bad_frame == (rate_index >= emfd_pkg::RATE_BAD_FIRST) && last_of_frame == (frame_bytes == 9'd0), "descriptor flags inconsistent")

endmodule

bind evs_mime_frame_deframer emfd_checker u_emfd_checker (
  .clk           (clk),
  .rst           (rst),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .result_kind   (result_kind),
  .payload_byte  (payload_byte),
  .amrwb_io_mode (amrwb_io_mode),
  .rate_index    (rate_index),
  .frame_bytes   (frame_bytes),
  .bad_frame     (bad_frame),
  .last_of_frame (last_of_frame),
  .header_fault  (header_fault)
);
